>>> src/erm_pkg.sv
// Shared types, constants and the segment table of the echo range meter.
`default_nettype none

package erm_pkg;

    // Fixed field and state widths
    localparam int unsigned ERM_COUNT_W   = 32;
    localparam int unsigned ERM_DIVISOR_W = 16;
    localparam int unsigned ERM_DIST_W    = 14;
    localparam int unsigned ERM_BCD_W     = 16;
    localparam int unsigned ERM_SEL_W     = 4;
    localparam int unsigned ERM_SEG_W     = 8;

    // Defaults
    localparam int unsigned ERM_DIGITS = 4;
    localparam logic [ERM_DIVISOR_W-1:0] ERM_DIVISOR_RESET = 16'd58;
    localparam logic [ERM_DIST_W-1:0]    ERM_DIST_MAX      = 14'd9999;

    // Handshake status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // Seven-segment pattern of one decimal digit, bit 0 unused
    function automatic logic [ERM_SEG_W-1:0] seg_pattern(input logic [3:0] digit);
        logic [ERM_SEG_W-1:0] pattern;
        case (digit)
            4'd0:    pattern = 8'h7E;
            4'd1:    pattern = 8'h0C;
            4'd2:    pattern = 8'hB6;
            4'd3:    pattern = 8'h9E;
            4'd4:    pattern = 8'hCC;
            4'd5:    pattern = 8'hDA;
            4'd6:    pattern = 8'hFA;
            4'd7:    pattern = 8'h4E;
            4'd8:    pattern = 8'hFE;
            4'd9:    pattern = 8'hCE;
            default: pattern = 8'h7E;
        endcase
        return pattern;
    endfunction

endpackage

`default_nettype wire

>>> src/erm_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
`default_nettype none

module erm_div
    import erm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [ERM_COUNT_W-1:0]   dividend,
    input  wire logic [ERM_DIVISOR_W-1:0] divisor,
    output      logic [ERM_COUNT_W-1:0]   quotient,
    output      unit_status_t             status
);

    localparam int unsigned CNT_W = $clog2(ERM_COUNT_W);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [ERM_COUNT_W-1:0]   dvd_reg, dvd_next;
    logic [ERM_DIVISOR_W-1:0] rem_reg, rem_next;
    logic [ERM_DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [ERM_DIVISOR_W:0]   trial;
    logic [ERM_DIVISOR_W:0]   diff;

    // Shift in the next dividend bit and try the subtraction
    assign trial = {rem_reg, dvd_reg[ERM_COUNT_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // Keep the difference when no borrow, quotient bit enters at the bottom
            if (!diff[ERM_DIVISOR_W])
            begin
                rem_next = diff[ERM_DIVISOR_W-1:0];
                dvd_next = {dvd_reg[ERM_COUNT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[ERM_DIVISOR_W-1:0];
                dvd_next = {dvd_reg[ERM_COUNT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ERM_COUNT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = dvd_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

>>> src/erm_bcd.sv
// Binary to four-digit BCD converter, shift-and-add-three, one bit per cycle.
`default_nettype none

module erm_bcd
    import erm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [ERM_DIST_W-1:0] bin,
    output      logic [ERM_BCD_W-1:0]  bcd,
    output      unit_status_t          status
);

    localparam int unsigned CNT_W = $clog2(ERM_DIST_W);
    localparam int unsigned NIBS  = ERM_BCD_W / 4;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ERM_DIST_W-1:0] shift_reg, shift_next;
    logic [ERM_BCD_W-1:0]  bcd_reg, bcd_next;
    logic [ERM_BCD_W-1:0]  adj;

    // Add three to every digit of five or more before the shift
    always_comb
    begin
        for (int n = 0; n < NIBS; n++)
        begin
            if (bcd_reg[4*n +: 4] >= 4'd5)
                adj[4*n +: 4] = bcd_reg[4*n +: 4] + 4'd3;
            else
                adj[4*n +: 4] = bcd_reg[4*n +: 4];
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = bin;
            bcd_next   = '0;
        end
        else if (busy_reg)
        begin
            bcd_next   = {adj[ERM_BCD_W-2:0], shift_reg[ERM_DIST_W-1]};
            shift_next = {shift_reg[ERM_DIST_W-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ERM_DIST_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign bcd         = bcd_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

>>> src/echo_range_meter_display.sv
// Operation: an item with tick set starts the divider on its pulse width; the saturated quotient
// is converted to BCD and one digit is registered to the output. An item without tick gives no result.
// Flow: no new item is taken while the bit-serial divider and BCD converter run; in_stall is high
// while they run and while a finished result waits for the output register.
// Reset: asynchronous, active low; clears counters, stamps, width, scan index, divisor to 58.
`default_nettype none

module echo_range_meter_display
    import erm_pkg::*;
#(
    parameter int unsigned DIGITS = ERM_DIGITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // APB configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output      logic [31:0]           prdata,
    output      logic                  pready,
    // Input channel
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire logic                  echo_rise,
    input  wire logic                  echo_fall,
    input  wire logic                  tick,
    // Output channel
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      logic [ERM_SEL_W-1:0]  digit_select,
    output      logic [ERM_SEG_W-1:0]  segment_code,
    output      logic [ERM_DIST_W-1:0] distance
);

    localparam int unsigned SCAN_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_BCD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [ERM_DIVISOR_W-1:0] divisor_reg;
    logic [ERM_COUNT_W-1:0]   tick_count_reg, tick_count_next;
    logic [ERM_COUNT_W-1:0]   rise_stamp_reg, rise_stamp_next;
    logic [ERM_COUNT_W-1:0]   pulse_width_reg, pulse_width_next;
    logic [SCAN_W-1:0]        scan_reg, scan_next;
    logic [ERM_DIST_W-1:0]    dist_reg, dist_next;
    logic                     out_valid_reg, out_valid_next;
    logic [ERM_SEL_W-1:0]     sel_reg, sel_next;
    logic [ERM_SEG_W-1:0]     seg_reg, seg_next;
    logic [ERM_DIST_W-1:0]    odist_reg, odist_next;

    logic                     in_xfer;
    logic                     cfg_write;
    logic                     div_start;
    logic                     bcd_start;
    logic [ERM_COUNT_W-1:0]   quotient;
    logic [ERM_BCD_W-1:0]     bcd_val;
    unit_status_t             div_st;
    unit_status_t             bcd_st;
    logic                     load_out;
    logic [2:0]               scan3;
    logic [2:0]               place3;
    logic [3:0]               digit;

    assign in_xfer   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = {16'd0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            divisor_reg <= ERM_DIVISOR_RESET;
        else if (cfg_write && !paddr[2])
            divisor_reg <= pwdata[ERM_DIVISOR_W-1:0];
    end

    // Stamp edges against the count before this transfer's tick
    always_comb
    begin
        rise_stamp_next  = rise_stamp_reg;
        pulse_width_next = pulse_width_reg;
        tick_count_next  = tick_count_reg;
        if (in_xfer)
        begin
            if (echo_rise)
                rise_stamp_next = tick_count_reg;
            if (echo_fall)
                pulse_width_next = tick_count_reg - rise_stamp_next;
            if (tick)
                tick_count_next = tick_count_reg + 1'b1;
        end
    end

    assign div_start = in_xfer && tick;
    assign bcd_start = div_st.done;

    // Saturate the quotient; a zero divisor yields all ones and so saturates too
    assign dist_next = (quotient > ERM_COUNT_W'(ERM_DIST_MAX)) ? ERM_DIST_MAX
                                                            : quotient[ERM_DIST_W-1:0];

    erm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (pulse_width_next),
        .divisor  (divisor_reg),
        .quotient (quotient),
        .status   (div_st)
    );

    // Convert the saturated quotient in the same cycle it is captured
    erm_bcd u_bcd
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (bcd_start),
        .bin    (dist_next),
        .bcd    (bcd_val),
        .status (bcd_st)
    );

    // Pick the digit shown at this scan position
    assign scan3  = 3'(scan_reg);
    assign place3 = 3'(DIGITS - 1) - scan3;
    assign digit  = place3[2] ? 4'd0 : bcd_val[{place3[1:0], 2'b00} +: 4];

    assign load_out = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        sel_next   = sel_reg;
        seg_next   = seg_reg;
        odist_next = odist_reg;
        scan_next  = scan_reg;
        if (load_out)
        begin
            sel_next   = scan3[2] ? '0 : (ERM_SEL_W'(1) << scan3[1:0]);
            seg_next   = seg_pattern(digit);
            odist_next = dist_reg;
            if (32'(scan_reg) + 32'd1 >= 32'(DIGITS))
                scan_next = '0;
            else
                scan_next = scan_reg + 1'b1;
        end
    end

    // Hold the result until the transfer, then drop valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // Sequence the divider and the converter
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (div_start)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_st.done)
                    state_next = ST_BCD;
            end
            ST_BCD:
            begin
                if (bcd_st.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            tick_count_reg  <= '0;
            rise_stamp_reg  <= '0;
            pulse_width_reg <= '0;
            scan_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            tick_count_reg  <= tick_count_next;
            rise_stamp_reg  <= rise_stamp_next;
            pulse_width_reg <= pulse_width_next;
            scan_reg        <= scan_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_st.done)
            dist_reg <= dist_next;
        sel_reg   <= sel_next;
        seg_reg   <= seg_next;
        odist_reg <= odist_next;
    end

    assign out_valid    = out_valid_reg;
    assign digit_select = sel_reg;
    assign segment_code = seg_reg;
    assign distance     = odist_reg;

    // Checks
    a_dist_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (distance <= ERM_DIST_MAX))
        else $error("distance above saturation limit");

    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(digit_select))
        else $error("digit select not one-hot");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside divide phase");

    a_bcd_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        bcd_st.done |-> (state_reg == ST_BCD))
        else $error("converter finished outside conversion phase");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == ST_DIV) && div_st.busy)
        else $error("divider did not start on tick transfer");

endmodule

`default_nettype wire
